// ===== rtl/osal_pkg.sv =====
package osal_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int COUNT_W = 9;
  localparam int WORD_W = 64;
  localparam int KEY_W = 4 * WORD_W;
  localparam int SUM_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

  typedef enum logic [1:0] {
    KIND_BATCH = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_CHECK = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_NO_BATCH  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t               kind;
    logic [COUNT_W-1:0]  batch_count;
    logic [WORD_W-1:0]   key_word0;
    logic [WORD_W-1:0]   key_word1;
    logic [WORD_W-1:0]   key_word2;
    logic [WORD_W-1:0]   key_word3;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic                allowed;
    logic [COUNT_W-1:0]  entry_count;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_EXEC    = 3'd1,
    ST_SCAN    = 3'd2,
    ST_MOVE_RD = 3'd3,
    ST_MOVE_WR = 3'd4
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic grab;
    logic miss;
    logic move_rd;
    logic move_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic is_check;
    logic empty;
    logic hit;
    logic scan_end;
  } dp_status_t;

endpackage

// ===== rtl/osal_datapath.sv =====
module osal_datapath
  import osal_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  dp_cmd_t    cmd,
  output dp_status_t stat,
  output logic       done,
  output result_t    result
);

  logic [KEY_W-1:0]   mem [TABLE_ENTRIES];
  logic [KEY_W-1:0]   rdata;
  logic [KEY_W-1:0]   key;
  item_t              item_q;
  logic [CNT_W-1:0]   held;
  logic [CNT_W-1:0]   held_next;
  logic [COUNT_W-1:0] batch_rem;
  logic [COUNT_W-1:0] batch_rem_next;
  logic [CNT_W-1:0]   scan_idx;
  logic [CNT_W-1:0]   scan_idx_next;
  logic               pend_valid;
  logic               pend_valid_next;
  logic [IDX_W-1:0]   pend_idx;
  logic [IDX_W-1:0]   match_idx;
  logic [CNT_W-1:0]   last_cnt;
  logic [SUM_W-1:0]   sum;
  logic               done_next;
  status_t            res_status;
  logic               res_allowed;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [KEY_W-1:0]   mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;

  assign key = {item_q.key_word3, item_q.key_word2, item_q.key_word1, item_q.key_word0};
  assign sum = SUM_W'(held) + SUM_W'(item_q.batch_count);
  assign last_cnt = held - CNT_W'(1);

  assign stat.is_check = (item_q.kind == KIND_CHECK);
  assign stat.empty    = (held == '0);
  assign stat.hit      = pend_valid && (rdata == key);
  assign stat.scan_end = (scan_idx == held) && !pend_valid;

  always_comb begin
    held_next       = held;
    batch_rem_next  = batch_rem;
    scan_idx_next   = scan_idx;
    pend_valid_next = pend_valid;
    done_next       = 1'b0;
    res_status      = STATUS_OK;
    res_allowed     = 1'b1;
    mem_we          = 1'b0;
    mem_waddr       = held[IDX_W-1:0];
    mem_wdata       = key;
    mem_re          = 1'b0;
    mem_raddr       = scan_idx[IDX_W-1:0];
    if (cmd.exec) begin
      pend_valid_next = 1'b0;
      unique case (item_q.kind)
        KIND_BATCH: begin
          done_next = 1'b1;
          if (sum > SUM_W'(TABLE_ENTRIES)) begin
            batch_rem_next = '0;
            res_status     = STATUS_TOO_LARGE;
            res_allowed    = 1'b0;
          end else begin
            batch_rem_next = item_q.batch_count;
          end
        end
        KIND_ADD: begin
          done_next = 1'b1;
          if (batch_rem == '0) begin
            res_status  = STATUS_NO_BATCH;
            res_allowed = 1'b0;
          end else if (held == CNT_W'(TABLE_ENTRIES)) begin
            batch_rem_next = '0;
            res_status     = STATUS_TOO_LARGE;
            res_allowed    = 1'b0;
          end else begin
            mem_we         = 1'b1;
            held_next      = held + CNT_W'(1);
            batch_rem_next = batch_rem - COUNT_W'(1);
          end
        end
        KIND_CHECK: begin
          if (held == '0) begin
            done_next = 1'b1;
          end else begin
            scan_idx_next = '0;
          end
        end
        default: begin
          done_next      = 1'b1;
          held_next      = '0;
          batch_rem_next = '0;
        end
      endcase
    end
    if (cmd.step) begin
      if (scan_idx != held) begin
        mem_re          = 1'b1;
        scan_idx_next   = scan_idx + CNT_W'(1);
        pend_valid_next = 1'b1;
      end else begin
        pend_valid_next = 1'b0;
      end
    end
    if (cmd.miss) begin
      done_next   = 1'b1;
      res_status  = STATUS_NOT_FOUND;
      res_allowed = 1'b0;
    end
    if (cmd.move_rd) begin
      mem_re    = 1'b1;
      mem_raddr = last_cnt[IDX_W-1:0];
    end
    if (cmd.move_wr) begin
      mem_we          = 1'b1;
      mem_waddr       = match_idx;
      mem_wdata       = rdata;
      held_next       = last_cnt;
      pend_valid_next = 1'b0;
      done_next       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      batch_rem  <= '0;
      scan_idx   <= '0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      held       <= held_next;
      batch_rem  <= batch_rem_next;
      scan_idx   <= scan_idx_next;
      pend_valid <= pend_valid_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.step && (scan_idx != held)) begin
      pend_idx <= scan_idx[IDX_W-1:0];
    end
    if (cmd.grab) begin
      match_idx <= pend_idx;
    end
    if (done_next) begin
      result.status      <= res_status;
      result.allowed     <= res_allowed;
      result.entry_count <= COUNT_W'(held_next);
    end
  end

`ifndef SYNTHESIS
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.exec || cmd.miss || cmd.move_wr))
    else $error("result without a finishing command");
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(TABLE_ENTRIES))
    else $error("held count beyond table size");
  a_pend_below: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (CNT_W'(pend_idx) < held))
    else $error("scan read beyond held entries");
  a_move_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.move_wr |-> (held != '0))
    else $error("swap-remove on empty list");
`endif

endmodule

// ===== rtl/osal_ctrl.sv =====
module osal_ctrl
  import osal_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t stat,
  output dp_cmd_t    cmd,
  output logic       busy
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_check && !stat.empty) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (stat.hit) begin
          cmd.grab   = 1'b1;
          state_next = ST_MOVE_RD;
        end else if (stat.scan_end) begin
          cmd.miss   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_MOVE_RD: begin
        cmd.move_rd = 1'b1;
        state_next  = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_EXEC))
    else $error("item load not followed by execute");
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.move_wr |-> $past(cmd.move_rd))
    else $error("swap write without last-entry read");
  a_grab_on_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.grab |-> (stat.hit && (state == ST_SCAN)))
    else $error("match captured without a hit");
`endif

endmodule

// ===== rtl/one_shot_allow_list_table.sv =====
// Batch start, add and clear: the item is registered, and the execute state acts on it and registers the result strobe.
// Check: the execute state, then a one-key-per-cycle scan of the key memory, plus
// the read and write of the swap-remove on a hit.
// One item in flight: the next start is taken in the cycle the result strobe is high.
// The result strobe lasts one cycle and cannot be stalled.
// Synchronous reset empties the list and closes any batch; key memory is not cleared.
module one_shot_allow_list_table
  import osal_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  osal_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  osal_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule
